FILE: rtl/vcis_pkg.sv
// vcis_pkg: types, constants and register indexes for the vehicle control input shaper
// used by vcis_cfg_regs, vcis_tick and vehicle_control_input_shaper_top; no dependencies
package vcis_pkg;

  localparam int LVL_W   = 15;
  localparam int STEER_W = 16;
  localparam int SPEED_W = 16;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THROTTLE_UP   = 3'd0,
    CFG_THROTTLE_DOWN = 3'd1,
    CFG_BRAKE_UP      = 3'd2,
    CFG_BRAKE_DOWN    = 3'd3,
    CFG_STEER_SLEW    = 3'd4,
    CFG_STEER_RETURN  = 3'd5
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_THROTTLE_UP   = 15'd328;
  localparam logic [CFG_W-1:0] RST_THROTTLE_DOWN = 15'd492;
  localparam logic [CFG_W-1:0] RST_BRAKE_UP      = 15'd492;
  localparam logic [CFG_W-1:0] RST_BRAKE_DOWN    = 15'd656;
  localparam logic [CFG_W-1:0] RST_STEER_SLEW    = 15'd492;
  localparam logic [CFG_W-1:0] RST_STEER_RETURN  = 15'd328;

  localparam logic [LVL_W-1:0]          LVL_ONE         = 15'd16384;
  localparam logic [LVL_W-1:0]          BRAKE_REV_REQ   = 15'd8192;
  localparam logic [LVL_W-1:0]          BRAKE_WRONG_DIR = 15'd13107;
  localparam logic signed [STEER_W-1:0] STEER_ONE       = 16'sd16384;
  localparam logic signed [STEER_W-1:0] STEER_NEG_ONE   = -16'sd16384;
  localparam logic signed [17:0]        STEER_DEAD_ZONE = 18'sd164;
  localparam logic signed [SPEED_W-1:0] SPEED_BAND1     = 16'sd160;
  localparam logic signed [SPEED_W-1:0] SPEED_BAND2     = 16'sd480;
  localparam logic signed [SPEED_W-1:0] SPEED_BAND3     = 16'sd960;
  localparam logic signed [SPEED_W-1:0] SPEED_ONE       = 16'sd16;
  localparam logic signed [SPEED_W-1:0] SPEED_NEG_ONE   = -16'sd16;
  localparam logic [16:0]               ABS_SPEED_ONE   = 17'd16;
  localparam logic [16:0]               ABS_SPEED_HALF  = 17'd8;
  // ceil(2^22 / 10), exact floor division by ten for operands below 2^18
  localparam logic [18:0] RECIP_TEN = 19'd419431;
  localparam int          RECIP_SHIFT = 22;

  typedef struct packed {
    logic [LVL_W-1:0]          throttle_pedal;
    logic [LVL_W-1:0]          brake_pedal;
    logic                      accelerate_button;
    logic                      brake_button;
    logic signed [STEER_W-1:0] steer_axis;
    logic                      left_button;
    logic                      right_button;
    logic                      reverse_button;
    logic signed [SPEED_W-1:0] vehicle_speed;
  } vcis_in_t;

  typedef struct packed {
    logic [LVL_W-1:0]          throttle_out;
    logic [LVL_W-1:0]          brake_out;
    logic signed [STEER_W-1:0] steer_out;
    logic                      reverse_out;
  } vcis_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] throttle_up_step;
    logic [CFG_W-1:0] throttle_down_step;
    logic [CFG_W-1:0] brake_up_step;
    logic [CFG_W-1:0] brake_down_step;
    logic [CFG_W-1:0] steer_slew_step;
    logic [CFG_W-1:0] steer_return_step;
  } vcis_cfg_t;

endpackage

FILE: rtl/vcis_cfg_regs.sv
// vcis_cfg_regs: step registers of the input shaper, written through a plain write port
// depends on vcis_pkg
module vcis_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vcis_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [vcis_pkg::CFG_W-1:0]    cfg_wdata,
  output vcis_pkg::vcis_cfg_t           cfg
);

  vcis_pkg::vcis_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        vcis_pkg::CFG_THROTTLE_UP:   cfg_nxt.throttle_up_step   = cfg_wdata;
        vcis_pkg::CFG_THROTTLE_DOWN: cfg_nxt.throttle_down_step = cfg_wdata;
        vcis_pkg::CFG_BRAKE_UP:      cfg_nxt.brake_up_step      = cfg_wdata;
        vcis_pkg::CFG_BRAKE_DOWN:    cfg_nxt.brake_down_step    = cfg_wdata;
        vcis_pkg::CFG_STEER_SLEW:    cfg_nxt.steer_slew_step    = cfg_wdata;
        vcis_pkg::CFG_STEER_RETURN:  cfg_nxt.steer_return_step  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_up_step   <= vcis_pkg::RST_THROTTLE_UP;
      cfg_r.throttle_down_step <= vcis_pkg::RST_THROTTLE_DOWN;
      cfg_r.brake_up_step      <= vcis_pkg::RST_BRAKE_UP;
      cfg_r.brake_down_step    <= vcis_pkg::RST_BRAKE_DOWN;
      cfg_r.steer_slew_step    <= vcis_pkg::RST_STEER_SLEW;
      cfg_r.steer_return_step  <= vcis_pkg::RST_STEER_RETURN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/vcis_tick.sv
// vcis_tick: per-tick shaping logic and the throttle, brake and steer level registers
// depends on vcis_pkg
module vcis_tick (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  vcis_pkg::vcis_cfg_t  cfg,
  input  vcis_pkg::vcis_in_t   in_item,
  output vcis_pkg::vcis_out_t  result
);

  logic [vcis_pkg::LVL_W-1:0]          thr_lvl_r, thr_lvl_nxt;
  logic [vcis_pkg::LVL_W-1:0]          brk_lvl_r, brk_lvl_nxt;
  logic signed [vcis_pkg::STEER_W-1:0] str_lvl_r, str_lvl_nxt;

  function automatic logic [vcis_pkg::LVL_W-1:0] ramp(
    input logic [vcis_pkg::LVL_W-1:0] lvl,
    input logic                       up,
    input logic [vcis_pkg::CFG_W-1:0] up_step,
    input logic [vcis_pkg::CFG_W-1:0] dn_step
  );
    logic signed [16:0] sum;
    if (up) sum = $signed({2'b00, lvl}) + $signed({2'b00, up_step});
    else    sum = $signed({2'b00, lvl}) - $signed({2'b00, dn_step});
    if (sum < 17'sd0) return '0;
    else if (sum > $signed({2'b00, vcis_pkg::LVL_ONE})) return vcis_pkg::LVL_ONE;
    else return sum[vcis_pkg::LVL_W-1:0];
  endfunction

  function automatic logic [vcis_pkg::LVL_W-1:0] sat_axis(input logic [vcis_pkg::LVL_W-1:0] a);
    return (a > vcis_pkg::LVL_ONE) ? vcis_pkg::LVL_ONE : a;
  endfunction

  logic signed [16:0] s_ext, abs_axis, spd_ext, abs_speed_s;
  logic [16:0]        abs_speed;
  logic signed [vcis_pkg::STEER_W-1:0] target;
  logic signed [17:0] lvl18, tgt18, slew18, up18, dn18;
  logic signed [vcis_pkg::STEER_W-1:0] slewed;
  logic [14:0]        mag;
  logic [17:0]        m18, xsc;
  logic [36:0]        prod;
  logic [14:0]        q;
  logic signed [15:0] sq;
  logic               rev;
  logic               wrong_dir;
  logic [vcis_pkg::LVL_W-1:0] brk_o;
  logic signed [17:0] ret18, cen18;

  always_comb begin
    // throttle and brake levels
    if (in_item.throttle_pedal != '0 || in_item.brake_pedal != '0) begin
      thr_lvl_nxt = sat_axis(in_item.throttle_pedal);
      brk_lvl_nxt = sat_axis(in_item.brake_pedal);
    end else begin
      thr_lvl_nxt = ramp(thr_lvl_r, in_item.accelerate_button,
                         cfg.throttle_up_step, cfg.throttle_down_step);
      brk_lvl_nxt = ramp(brk_lvl_r, in_item.brake_button,
                         cfg.brake_up_step, cfg.brake_down_step);
    end

    // steer target
    s_ext    = 17'(in_item.steer_axis);
    abs_axis = (s_ext < 17'sd0) ? -s_ext : s_ext;
    if (18'(abs_axis) >= vcis_pkg::STEER_DEAD_ZONE) begin
      if (in_item.steer_axis > vcis_pkg::STEER_ONE)          target = vcis_pkg::STEER_ONE;
      else if (in_item.steer_axis < vcis_pkg::STEER_NEG_ONE) target = vcis_pkg::STEER_NEG_ONE;
      else                                                   target = in_item.steer_axis;
    end else if (in_item.left_button && !in_item.right_button) begin
      target = vcis_pkg::STEER_ONE;
    end else if (in_item.right_button && !in_item.left_button) begin
      target = vcis_pkg::STEER_NEG_ONE;
    end else begin
      target = '0;
    end

    // slew toward target without overshoot
    lvl18 = 18'(str_lvl_r);
    tgt18 = 18'(target);
    up18  = lvl18 + $signed({3'b000, cfg.steer_slew_step});
    dn18  = lvl18 - $signed({3'b000, cfg.steer_slew_step});
    if (tgt18 > lvl18)      slew18 = (up18 < tgt18) ? up18 : tgt18;
    else if (tgt18 < lvl18) slew18 = (dn18 > tgt18) ? dn18 : tgt18;
    else                    slew18 = lvl18;
    slewed = slew18[vcis_pkg::STEER_W-1:0];

    // speed band scaling, round half away from zero
    mag = (slewed < 16'sd0) ? 15'(-slewed) : 15'(slewed);
    m18 = {3'b000, mag};
    if (in_item.vehicle_speed < vcis_pkg::SPEED_BAND1)      xsc = (m18 << 3) + (m18 << 1);
    else if (in_item.vehicle_speed < vcis_pkg::SPEED_BAND2) xsc = m18 << 3;
    else if (in_item.vehicle_speed < vcis_pkg::SPEED_BAND3) xsc = (m18 << 2) + (m18 << 1);
    else                                                    xsc = m18 << 2;
    xsc  = xsc + 18'd5;
    prod = 37'(xsc) * 37'(vcis_pkg::RECIP_TEN);
    q    = prod[vcis_pkg::RECIP_SHIFT +: 15];
    sq   = $signed({1'b0, q});
    result.steer_out = (slewed < 16'sd0) ? -sq : sq;

    // reverse and direction rules
    spd_ext     = 17'(in_item.vehicle_speed);
    abs_speed_s = (spd_ext < 17'sd0) ? -spd_ext : spd_ext;
    abs_speed   = abs_speed_s;
    rev   = in_item.reverse_button && (abs_speed < vcis_pkg::ABS_SPEED_ONE);
    brk_o = brk_lvl_nxt;
    if (in_item.reverse_button && !rev && brk_o < vcis_pkg::BRAKE_REV_REQ)
      brk_o = vcis_pkg::BRAKE_REV_REQ;
    wrong_dir = (rev && in_item.vehicle_speed > vcis_pkg::SPEED_ONE) ||
                (!rev && in_item.vehicle_speed < vcis_pkg::SPEED_NEG_ONE);
    result.throttle_out = thr_lvl_nxt;
    if (wrong_dir) begin
      if (brk_o < vcis_pkg::BRAKE_WRONG_DIR) brk_o = vcis_pkg::BRAKE_WRONG_DIR;
      result.throttle_out = '0;
    end
    result.brake_out   = brk_o;
    result.reverse_out = rev;

    // self-centering for the next tick
    ret18 = $signed({3'b000, cfg.steer_return_step});
    cen18 = slew18;
    if (!in_item.left_button && !in_item.right_button && abs_speed > vcis_pkg::ABS_SPEED_HALF) begin
      if (slew18 >= vcis_pkg::STEER_DEAD_ZONE) begin
        cen18 = slew18 - ret18;
        if (cen18 < 18'sd0) cen18 = '0;
      end else if (slew18 <= -vcis_pkg::STEER_DEAD_ZONE) begin
        cen18 = slew18 + ret18;
        if (cen18 > 18'sd0) cen18 = '0;
      end
    end
    str_lvl_nxt = cen18[vcis_pkg::STEER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lvl_r <= '0;
      brk_lvl_r <= '0;
      str_lvl_r <= '0;
    end else if (fire) begin
      thr_lvl_r <= thr_lvl_nxt;
      brk_lvl_r <= brk_lvl_nxt;
      str_lvl_r <= str_lvl_nxt;
    end
  end

endmodule

FILE: rtl/vehicle_control_input_shaper_top.sv
// vehicle_control_input_shaper_top: input register, tick logic and result register
// depends on vcis_pkg, vcis_cfg_regs and vcis_tick
//
// One input transfer is one control tick carrying the driver inputs and the
// signed vehicle speed; each tick gives exactly one result transfer with
// throttle, brake, steer and reverse commands.
// A tick accepted into the input register is processed and placed in the result
// register once that register is free or being read.
// Throughput: one tick per cycle while the receiver does not stall; the level
// registers update once per tick, which is the loop that sets that rate.
// When the receiver stalls the result register holds, and the input register
// still takes one more tick; in_ready drops only when both are full.
// Reset: the step registers take their default values, the throttle, brake
// and steer levels clear to zero and both pipeline stages empty.
// Step registers go through cfg_we/cfg_addr/cfg_wdata; unknown indexes are ignored.
// The user must write them only while the block is idle, which is not enforced.
module vehicle_control_input_shaper_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vcis_pkg::vcis_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vcis_pkg::vcis_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [vcis_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [vcis_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                in_valid_r;
  vcis_pkg::vcis_in_t  in_data_r;
  logic                out_valid_r;
  vcis_pkg::vcis_out_t out_data_r;
  vcis_pkg::vcis_out_t result;
  vcis_pkg::vcis_cfg_t cfg;
  logic                advance;
  logic                fire;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  vcis_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vcis_tick u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .cfg     (cfg),
    .in_item (in_data_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance)  out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
    if (fire)                 out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a processed tick always lands in the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed tick did not reach the result register");

  // back-pressure only when both stages hold a tick
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage was free");

  // level commands stay within 0..1.0
  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.throttle_out <= vcis_pkg::LVL_ONE &&
                   out_data.brake_out <= vcis_pkg::LVL_ONE))
    else $error("throttle or brake command out of range");

  // steer command within -1.0..1.0
  a_steer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.steer_out <= vcis_pkg::STEER_ONE &&
                   out_data.steer_out >= vcis_pkg::STEER_NEG_ONE))
    else $error("steer command out of range");

endmodule

FILE: dv/vcis_command_checker.sv
// vcis_command_checker: predicts the commands of every control tick and checks the result channel
// depends on vcis_pkg; sits beside the shaper and watches its input, result and register ports
module vcis_command_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  vcis_pkg::vcis_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  vcis_pkg::vcis_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [vcis_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [vcis_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           end_check,
  output int                             fail_count,
  output int                             pending
);

  int thr_up, thr_down, brk_up, brk_down, slew_step, return_step;
  int thr_lvl, brk_lvl, str_lvl;
  vcis_pkg::vcis_out_t expected_cmds[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic vcis_pkg::vcis_out_t shape_tick(input vcis_pkg::vcis_in_t x);
    int t_axis, b_axis, s_axis, spd, abs_spd, abs_axis;
    int target, thr, brk, tenths, mag, scaled;
    bit granted;
    vcis_pkg::vcis_out_t r;
    t_axis = int'(x.throttle_pedal);
    b_axis = int'(x.brake_pedal);
    s_axis = int'($signed(x.steer_axis));
    spd = int'($signed(x.vehicle_speed));
    abs_spd = (spd < 0) ? -spd : spd;
    abs_axis = (s_axis < 0) ? -s_axis : s_axis;

    if (t_axis > 0 || b_axis > 0) begin
      thr_lvl = clip(t_axis, 0, 16384);
      brk_lvl = clip(b_axis, 0, 16384);
    end else begin
      thr_lvl = x.accelerate_button ? clip(thr_lvl + thr_up, 0, 16384)
                                    : clip(thr_lvl - thr_down, 0, 16384);
      brk_lvl = x.brake_button ? clip(brk_lvl + brk_up, 0, 16384)
                               : clip(brk_lvl - brk_down, 0, 16384);
    end
    thr = thr_lvl;
    brk = brk_lvl;

    if (abs_axis >= 164) target = clip(s_axis, -16384, 16384);
    else if (x.left_button && !x.right_button) target = 16384;
    else if (x.right_button && !x.left_button) target = -16384;
    else target = 0;

    if (target > str_lvl) str_lvl = (str_lvl + slew_step < target) ? str_lvl + slew_step : target;
    else if (target < str_lvl)
      str_lvl = (str_lvl - slew_step > target) ? str_lvl - slew_step : target;

    if (spd < 160) tenths = 10;
    else if (spd < 480) tenths = 8;
    else if (spd < 960) tenths = 6;
    else tenths = 4;
    mag = (str_lvl < 0) ? -str_lvl : str_lvl;
    mag = (mag * tenths * 2 + 10) / 20;
    scaled = clip((str_lvl < 0) ? -mag : mag, -16384, 16384);

    granted = 1'b0;
    if (x.reverse_button) begin
      if (abs_spd < 16) granted = 1'b1;
      else if (brk < 8192) brk = 8192;
    end
    if ((granted && spd > 16) || (!granted && spd < -16)) begin
      if (brk < 13107) brk = 13107;
      thr = 0;
    end

    // self-centering only shows on the next tick
    if (!x.left_button && !x.right_button && abs_spd > 8) begin
      if (str_lvl >= 164) str_lvl = (str_lvl - return_step > 0) ? str_lvl - return_step : 0;
      else if (str_lvl <= -164)
        str_lvl = (str_lvl + return_step < 0) ? str_lvl + return_step : 0;
    end

    r.throttle_out = vcis_pkg::LVL_W'(thr);
    r.brake_out = vcis_pkg::LVL_W'(brk);
    r.steer_out = vcis_pkg::STEER_W'(scaled);
    r.reverse_out = granted;
    return r;
  endfunction

  always @(posedge clk) begin
    vcis_pkg::vcis_out_t exp_cmd;
    if (!rst_n) begin
      thr_up = int'(vcis_pkg::RST_THROTTLE_UP);
      thr_down = int'(vcis_pkg::RST_THROTTLE_DOWN);
      brk_up = int'(vcis_pkg::RST_BRAKE_UP);
      brk_down = int'(vcis_pkg::RST_BRAKE_DOWN);
      slew_step = int'(vcis_pkg::RST_STEER_SLEW);
      return_step = int'(vcis_pkg::RST_STEER_RETURN);
      thr_lvl = 0;
      brk_lvl = 0;
      str_lvl = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          vcis_pkg::CFG_THROTTLE_UP:   thr_up = int'(cfg_wdata);
          vcis_pkg::CFG_THROTTLE_DOWN: thr_down = int'(cfg_wdata);
          vcis_pkg::CFG_BRAKE_UP:      brk_up = int'(cfg_wdata);
          vcis_pkg::CFG_BRAKE_DOWN:    brk_down = int'(cfg_wdata);
          vcis_pkg::CFG_STEER_SLEW:    slew_step = int'(cfg_wdata);
          vcis_pkg::CFG_STEER_RETURN:  return_step = int'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_cmds.push_back(shape_tick(in_data));
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result transfer with no command expected");
          fail_count++;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          if (out_data.throttle_out !== exp_cmd.throttle_out) begin
            $error("throttle_out: expected %0d, got %0d",
                   exp_cmd.throttle_out, out_data.throttle_out);
            fail_count++;
          end
          if (out_data.brake_out !== exp_cmd.brake_out) begin
            $error("brake_out: expected %0d, got %0d", exp_cmd.brake_out, out_data.brake_out);
            fail_count++;
          end
          if (out_data.steer_out !== exp_cmd.steer_out) begin
            $error("steer_out: expected %0d, got %0d", exp_cmd.steer_out, out_data.steer_out);
            fail_count++;
          end
          if (out_data.reverse_out !== exp_cmd.reverse_out) begin
            $error("reverse_out: expected %0d, got %0d",
                   exp_cmd.reverse_out, out_data.reverse_out);
            fail_count++;
          end
        end
      end
      if (end_check && expected_cmds.size() != 0) begin
        $error("%0d expected commands never arrived", expected_cmds.size());
        fail_count++;
      end
    end
    pending = expected_cmds.size();
  end

endmodule

FILE: dv/vehicle_control_input_shaper_top_tb.sv
// vehicle_control_input_shaper_top_tb: clock, reset, tick stimulus, register phases and verdict
// depends on vcis_pkg, vehicle_control_input_shaper_top and vcis_command_checker
module vehicle_control_input_shaper_top_tb;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  vcis_pkg::vcis_in_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  vcis_pkg::vcis_out_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [vcis_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [vcis_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           end_check = 1'b0;
  int                             fail_count;
  int                             pending;
  int                             send_idle_pct = 0;
  int                             ready_stall_pct = 0;
  bit                             held_acc, held_brk, held_left, held_right, held_rev;
  int                             speed_marks[16] = '{-17, -16, -15, -9, -8, 8, 9, 15, 16, 17,
                                                      159, 160, 479, 480, 959, 960};

  vehicle_control_input_shaper_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  vcis_command_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .end_check  (end_check),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial forever begin
    @(posedge clk);
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  function automatic vcis_pkg::vcis_in_t tick(input int t_axis, input int b_axis, input bit acc,
                                              input bit brk, input int s_axis, input bit left,
                                              input bit right, input bit rev, input int spd);
    vcis_pkg::vcis_in_t x;
    x.throttle_pedal = vcis_pkg::LVL_W'(t_axis);
    x.brake_pedal = vcis_pkg::LVL_W'(b_axis);
    x.accelerate_button = acc;
    x.brake_button = brk;
    x.steer_axis = vcis_pkg::STEER_W'(s_axis);
    x.left_button = left;
    x.right_button = right;
    x.reverse_button = rev;
    x.vehicle_speed = vcis_pkg::SPEED_W'(spd);
    return x;
  endfunction

  // buttons stay held over runs of ticks so the levels reach their clamps
  function automatic vcis_pkg::vcis_in_t rand_tick();
    vcis_pkg::vcis_in_t x;
    int pick;
    if ($urandom_range(99) < 20) held_acc = ~held_acc;
    if ($urandom_range(99) < 20) held_brk = ~held_brk;
    if ($urandom_range(99) < 20) held_left = ~held_left;
    if ($urandom_range(99) < 20) held_right = ~held_right;
    if ($urandom_range(99) < 15) held_rev = ~held_rev;
    x = tick(0, 0, held_acc, held_brk, 0, held_left, held_right, held_rev, 0);
    pick = $urandom_range(99);
    if (pick >= 92) x.throttle_pedal = vcis_pkg::LVL_W'($urandom);
    else if (pick >= 80) x.throttle_pedal = vcis_pkg::LVL_W'($urandom_range(16384, 1));
    pick = $urandom_range(99);
    if (pick >= 92) x.brake_pedal = vcis_pkg::LVL_W'($urandom);
    else if (pick >= 80) x.brake_pedal = vcis_pkg::LVL_W'($urandom_range(16384, 1));
    pick = $urandom_range(99);
    if (pick < 30) x.steer_axis = vcis_pkg::STEER_W'(int'($urandom_range(340)) - 170);
    else if (pick < 55) x.steer_axis = '0;
    else if (pick < 85) x.steer_axis = vcis_pkg::STEER_W'(int'($urandom_range(32768)) - 16384);
    else x.steer_axis = vcis_pkg::STEER_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) x.vehicle_speed = vcis_pkg::SPEED_W'(int'($urandom_range(48)) - 24);
    else if (pick < 70) x.vehicle_speed = vcis_pkg::SPEED_W'(int'($urandom_range(2400)) - 1200);
    else if (pick < 90) x.vehicle_speed = vcis_pkg::SPEED_W'(speed_marks[$urandom_range(15)]);
    else x.vehicle_speed = vcis_pkg::SPEED_W'($urandom);
    return x;
  endfunction

  task automatic send_tick(input vcis_pkg::vcis_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vcis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vcis_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    logic [vcis_pkg::CFG_W-1:0] step_vals[6];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // indexes past the last register must be ignored
    for (int i = vcis_pkg::CFG_STEER_RETURN + 1; i < 2 ** vcis_pkg::CFG_IDX_W; i++)
      write_reg(vcis_pkg::CFG_IDX_W'(i), vcis_pkg::CFG_W'($urandom));
    cfg_we <= 1'b0;

    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(16384, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(32767, 32767, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(0, 1, 1, 1, 0, 0, 0, 0, 0));
    send_tick(tick(0, 0, 1, 0, 32767, 0, 0, 0, 0));
    send_tick(tick(0, 0, 1, 1, -32768, 0, 0, 0, 159));
    send_tick(tick(0, 0, 0, 1, 163, 1, 0, 0, 160));
    send_tick(tick(0, 0, 0, 0, 164, 0, 1, 0, 479));
    send_tick(tick(0, 0, 0, 0, -164, 0, 0, 0, 480));
    send_tick(tick(0, 0, 0, 0, -163, 1, 1, 0, 959));
    send_tick(tick(0, 0, 0, 0, 0, 1, 0, 0, 960));
    send_tick(tick(0, 0, 0, 0, 0, 1, 0, 0, 32767));
    send_tick(tick(0, 0, 0, 0, 0, 1, 0, 0, -32768));
    send_tick(tick(0, 0, 0, 0, 0, 0, 1, 0, 0));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 1, 15));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 1, 16));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 1, -15));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 1, -17));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 0, -17));
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 0, -16));
    send_tick(tick(0, 0, 0, 0, 0, 1, 0, 0, 8));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 8));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 9));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, -9));

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      for (int i = vcis_pkg::CFG_THROTTLE_UP; i <= vcis_pkg::CFG_STEER_RETURN; i++) begin
        case (ph)
          0: step_vals[i] = vcis_pkg::CFG_W'($urandom_range(1000, 1));
          1: step_vals[i] = '0;
          2: step_vals[i] = vcis_pkg::LVL_ONE;
          3: step_vals[i] = '1;
          4: step_vals[i] = vcis_pkg::CFG_W'($urandom);
          default: step_vals = '{vcis_pkg::RST_THROTTLE_UP, vcis_pkg::RST_THROTTLE_DOWN,
                                 vcis_pkg::RST_BRAKE_UP, vcis_pkg::RST_BRAKE_DOWN,
                                 vcis_pkg::RST_STEER_SLEW, vcis_pkg::RST_STEER_RETURN};
        endcase
      end
      for (int i = vcis_pkg::CFG_THROTTLE_UP; i <= vcis_pkg::CFG_STEER_RETURN; i++)
        write_reg(vcis_pkg::CFG_IDX_W'(i), step_vals[i]);
      cfg_we <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 68; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 68; end
        default: begin send_idle_pct = 20; ready_stall_pct = 20; end
      endcase
      for (int n = 0; n < 108; n++) begin
        if (n == 54) wait_drained();
        send_tick(rand_tick());
      end
    end

    wait_drained();
    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/vcis_pkg.sv
rtl/vcis_cfg_regs.sv
rtl/vcis_tick.sv
rtl/vehicle_control_input_shaper_top.sv
dv/vcis_command_checker.sv
dv/vehicle_control_input_shaper_top_tb.sv
